>>> hdl/mqpp_pkg.sv
// Package: shared constants, command and status codes for the queue placer.
`default_nettype none
package mqpp_pkg;
    localparam int MAXQ_DEF   = 8;
    localparam int QDEPTH_DEF = 16;

    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DEQ = 2'd1;
    localparam logic [1:0] CMD_ADD = 2'd2;
    localparam logic [1:0] CMD_REM = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_BADQ  = 3'd3;
    localparam logic [2:0] ST_LIMIT = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_SCAN,
        S_PLACE,
        S_REM,
        S_DONE
    } state_t;

    // Operation broadcast to every cell of one queue
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_POP,
        OP_LOAD,
        OP_CLEAR
    } cell_op_t;

    // One slot entry
    typedef struct packed {
        logic        [15:0] tag;
        logic signed [15:0] prio;
    } slot_t;
endpackage
`default_nettype wire

>>> hdl/multi_queue_priority_placer_top.sv
// Top level: command sequencer over a bank of cell-chain queues.
//
// Keeps up to MAXQ ascending priority queues of QDEPTH cells each; two queues
// are active after reset. Every queue is a chain of cells that compare and
// shift in parallel, so enqueue passes through decode, a search of all
// queues, picking the queue and inserting, and forming the result; dequeue
// and add queue pass through decode and forming the result. Remove queue
// shifts higher queues down one row at once and then re-enqueues each held
// entry through the same search and insert. One request is in work at a
// time and the next one is taken in the cycle after its result is formed;
// the result register lets the next request be taken while a result waits.
`default_nettype none
module multi_queue_priority_placer_top
    import mqpp_pkg::*;
#(
    parameter int MAXQ   = MAXQ_DEF,
    parameter int QDEPTH = QDEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cmd[1:0]
    input  wire logic [1:0]  s_tuser,
    // entry_tag[15:0], entry_priority[31:16], queue_number[35:32], pad
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], out_tag[18:3], placed_queue[22:19], total_entries[30:23],
    // queue_count[34:31], pad
    output logic [39:0]      m_tdata
);
    localparam int FW = $clog2(QDEPTH + 1);
    localparam int QW = $clog2(MAXQ + 1);
    localparam int IW = (MAXQ > 1) ? $clog2(MAXQ) : 1;
    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    state_t state_reg, state_next;
    logic [1:0]  cmd_reg;
    slot_t       req_reg;
    logic [3:0]  qn_reg;
    logic [QW-1:0] act_reg, act_next;
    logic [2:0]  st_reg;
    logic [15:0] otag_reg;
    logic [3:0]  placed_reg;
    logic        rem_reg;
    slot_t       held_reg [QDEPTH];
    logic [FW-1:0] held_n_reg, held_k_reg;
    logic [FW-1:0] pos_reg [MAXQ];
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    cell_op_t op [MAXQ];
    slot_t    new_slot;
    slot_t    slots [MAXQ][QDEPTH];
    slot_t    load_slots [MAXQ][QDEPTH];
    logic [FW-1:0] fill [MAXQ];
    logic [FW-1:0] load_fill [MAXQ];
    logic [FW-1:0] pos [MAXQ];
    logic [IW-1:0] best_c;
    logic [FW-1:0] best_pos_c;
    logic          found_c;
    logic [7:0]    total_c;
    logic          qn_ok;
    logic [IW-1:0] qi;

    assign new_slot = (cmd_reg == CMD_REM) ? held_reg[held_k_reg[PW-1:0]] : req_reg;
    assign qn_ok = (qn_reg >= 4'd1) && ({4'd0, qn_reg} <= 8'(act_reg));
    assign qi = IW'(qn_reg - 4'd1);

    genvar g;
    generate
        for (g = 0; g < MAXQ; g++)
        begin : g_q
            // Remove shifts queue g+1 into g
            if (g == MAXQ - 1)
            begin : g_top
                assign load_slots[g] = slots[g];
                assign load_fill[g]  = '0;
            end
            else
            begin : g_low
                assign load_slots[g] = slots[g+1];
                assign load_fill[g]  = fill[g+1];
            end
            mqpp_queue #(.QDEPTH(QDEPTH)) u_queue (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op[g]),
                .new_slot   (new_slot),
                .load_slots (load_slots[g]),
                .load_fill  (load_fill[g]),
                .slots      (slots[g]),
                .fill       (fill[g]),
                .pos        (pos[g])
            );
        end
    endgenerate

    // Pick smallest registered position, lowest index on ties
    always_comb
    begin
        best_c = '0;
        best_pos_c = '0;
        found_c = 1'b0;
        for (int q = 0; q < MAXQ; q++)
            if (QW'(q) < act_reg && (!found_c || pos_reg[q] < best_pos_c))
            begin
                found_c = 1'b1;
                best_c = IW'(q);
                best_pos_c = pos_reg[q];
            end
    end

    // Sum fills of active queues
    always_comb
    begin
        total_c = '0;
        for (int q = 0; q < MAXQ; q++)
            if (QW'(q) < act_reg)
                total_c = total_c + 8'(fill[q]);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        act_next = act_reg;
        for (int q = 0; q < MAXQ; q++)
            op[q] = OP_NONE;
        s_tready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
                if (s_tvalid && s_tready)
                    state_next = S_CMD;
            S_CMD:
            begin
                unique case (cmd_reg)
                    CMD_ENQ: state_next = S_SCAN;
                    CMD_DEQ:
                    begin
                        if (qn_ok && fill[qi] != '0)
                            op[qi] = OP_POP;
                        state_next = S_DONE;
                    end
                    CMD_ADD:
                    begin
                        if (32'(act_reg) < MAXQ)
                        begin
                            op[IW'(act_reg)] = OP_CLEAR;
                            act_next = act_reg + QW'(1);
                        end
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        if (qn_ok)
                        begin
                            for (int q = 0; q < MAXQ; q++)
                                if (q >= 32'(qi) && QW'(q) + QW'(1) < act_reg)
                                    op[q] = OP_LOAD;
                                else if (QW'(q) + QW'(1) == act_reg)
                                    op[q] = OP_CLEAR;
                            act_next = act_reg - QW'(1);
                            state_next = S_REM;
                        end
                        else
                            state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN: state_next = S_PLACE;
            S_PLACE:
            begin
                if (found_c && fill[best_c] < FW'(QDEPTH))
                    op[best_c] = OP_INSERT;
                state_next = (cmd_reg == CMD_REM) ? S_REM : S_DONE;
            end
            S_REM:
                state_next = (held_k_reg < held_n_reg) ? S_SCAN : S_DONE;
            S_DONE:
                if (!m_tvalid_reg || m_tready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg <= QW'(2);
            m_tvalid_reg <= 1'b0;
            rem_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg <= act_next;
            if (state_reg == S_DONE && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            rem_reg <= (state_reg == S_CMD && cmd_reg == CMD_REM && qn_ok);
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser;
            req_reg.tag <= s_tdata[15:0];
            req_reg.prio <= s_tdata[31:16];
            qn_reg <= s_tdata[35:32];
            st_reg <= ST_OK;
            otag_reg <= '0;
            placed_reg <= '0;
            held_k_reg <= '0;
            held_n_reg <= '0;
        end
        if (state_reg == S_CMD)
        begin
            unique case (cmd_reg)
                CMD_DEQ:
                    if (!qn_ok)
                        st_reg <= ST_BADQ;
                    else if (fill[qi] == '0)
                        st_reg <= ST_EMPTY;
                    else
                        otag_reg <= slots[qi][0].tag;
                CMD_ADD:
                    if (32'(act_reg) >= MAXQ)
                        st_reg <= ST_LIMIT;
                CMD_REM:
                    if (!qn_ok)
                        st_reg <= ST_BADQ;
                    else
                    begin
                        held_reg <= slots[qi];
                        held_n_reg <= fill[qi];
                    end
                default: ;
            endcase
        end
        if (state_reg == S_SCAN)
            pos_reg <= pos;
        if (state_reg == S_PLACE)
        begin
            held_k_reg <= held_k_reg + FW'(1);
            if (!(found_c && fill[best_c] < FW'(QDEPTH)))
                st_reg <= ST_FULL;
            else if (cmd_reg == CMD_ENQ)
                placed_reg <= 4'(best_c) + 4'd1;
        end
        if (state_reg == S_DONE && (!m_tvalid_reg || m_tready))
            m_tdata_reg <= {5'd0, 4'(act_reg), total_c, placed_reg, otag_reg, st_reg};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Search and pick must use the positions registered in the scan state just before
    a_scan_to_place: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |=> state_reg == S_PLACE)
        else $error("scan not followed by place");
    a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(act_reg) <= MAXQ)
        else $error("active count above limit");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !s_tready)
        else $error("request taken while busy");
    a_remove_step: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg |-> state_reg == S_REM)
        else $error("remove did not enter re-enqueue");
endmodule
`default_nettype wire

>>> hdl/mqpp_cell.sv
// One slot cell: holds one entry and shifts with its neighbors.
`default_nettype none
module mqpp_cell
    import mqpp_pkg::*;
(
    input  wire logic        clk,
    input  wire cell_op_t    op,
    input  wire logic        ins_here,   // insert point is this cell
    input  wire logic        ins_below,  // insert point is before this cell
    input  wire slot_t       new_slot,
    input  wire slot_t       prev_slot,
    input  wire slot_t       next_slot,
    input  wire slot_t       load_slot,
    input  wire logic signed [15:0] cmp_prio,
    output logic             ge,         // held priority >= cmp_prio
    output slot_t            slot
);
    slot_t slot_reg;
    slot_t slot_next;

    assign slot = slot_reg;
    assign ge   = slot_reg.prio >= cmp_prio;

    // Pick next contents from op
    always_comb
    begin
        slot_next = slot_reg;
        unique case (op)
            OP_INSERT:
            begin
                if (ins_here)
                    slot_next = new_slot;
                else if (ins_below)
                    slot_next = prev_slot;
            end
            OP_POP:   slot_next = next_slot;
            OP_LOAD:  slot_next = load_slot;
            OP_CLEAR: slot_next = slot_reg;
            default:  slot_next = slot_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end
endmodule
`default_nettype wire

>>> hdl/mqpp_queue.sv
// One queue: a row of cells with fill count and insert position search.
`default_nettype none
module mqpp_queue
    import mqpp_pkg::*;
#(
    parameter int QDEPTH = QDEPTH_DEF,
    localparam int FW = $clog2(QDEPTH + 1)
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cell_op_t    op,
    input  wire slot_t       new_slot,
    input  wire slot_t       load_slots [QDEPTH],
    input  wire logic [FW-1:0] load_fill,
    output slot_t            slots [QDEPTH],
    output logic [FW-1:0]    fill,
    output logic [FW-1:0]    pos
);
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [QDEPTH-1:0] ge;
    logic [QDEPTH-1:0] hit;
    slot_t prv [QDEPTH];
    slot_t nxt [QDEPTH];

    assign fill = fill_reg;

    // Mark cells that are valid and at or above the new priority
    always_comb
    begin
        for (int i = 0; i < QDEPTH; i++)
            hit[i] = ge[i] && (FW'(i) < fill_reg);
    end

    // First hit, or fill when none; cells are sorted so hits are a suffix
    always_comb
    begin
        pos = fill_reg;
        for (int i = QDEPTH - 1; i >= 0; i--)
            if (hit[i])
                pos = FW'(i);
    end

    genvar g;
    generate
        for (g = 0; g < QDEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign prv[g] = new_slot;
            end
            else
            begin : g_rest
                assign prv[g] = slots[g-1];
            end
            if (g == QDEPTH - 1)
            begin : g_last
                assign nxt[g] = slots[g];
            end
            else
            begin : g_mid
                assign nxt[g] = slots[g+1];
            end
            mqpp_cell u_cell (
                .clk       (clk),
                .op        (op),
                .ins_here  (pos == FW'(g)),
                .ins_below (pos < FW'(g)),
                .new_slot  (new_slot),
                .prev_slot (prv[g]),
                .next_slot (nxt[g]),
                .load_slot (load_slots[g]),
                .cmp_prio  (new_slot.prio),
                .ge        (ge[g]),
                .slot      (slots[g])
            );
        end
    endgenerate

    // Track fill with op
    always_comb
    begin
        fill_next = fill_reg;
        unique case (op)
            OP_INSERT: fill_next = fill_reg + FW'(1);
            OP_POP:    fill_next = fill_reg - FW'(1);
            OP_LOAD:   fill_next = load_fill;
            OP_CLEAR:  fill_next = '0;
            default:   fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end
endmodule
`default_nettype wire
